@@ rtl/avr_alu_pkg.sv @@
// shared codes and stream packing constants for the avr alu slice
// used by avr_alu_add_sub_movw_top and avr_alu_chk; no dependencies
`default_nettype none

package avr_alu_pkg;

  // register file size
  localparam int NUM_REGS_DEF = 32;

  // stream widths
  localparam int IN_TDATA_W  = 32;
  localparam int IN_TUSER_W  = 2;
  localparam int OUT_TDATA_W = 40;
  localparam int OUT_TUSER_W = 3;

  // host operation codes (in_tuser)
  localparam logic [1:0] OP_EXEC    = 2'd0;
  localparam logic [1:0] OP_WR_REG  = 2'd1;
  localparam logic [1:0] OP_RD_REG  = 2'd2;
  localparam logic [1:0] OP_WR_SREG = 2'd3;

  // reg_written codes
  localparam logic [1:0] WR_NONE = 2'd0;
  localparam logic [1:0] WR_BYTE = 2'd1;
  localparam logic [1:0] WR_PAIR = 2'd2;

  // instruction word bits 13..10 of the arithmetic group
  localparam logic [3:0] KIND_CPC = 4'b0001;
  localparam logic [3:0] KIND_SBC = 4'b0010;
  localparam logic [3:0] KIND_ADD = 4'b0011;
  localparam logic [3:0] KIND_CP  = 4'b0101;
  localparam logic [3:0] KIND_SUB = 4'b0110;
  localparam logic [3:0] KIND_ADC = 4'b0111;

  // bits 9..8 of the misc group
  localparam logic [1:0] MISC_NOP  = 2'b00;
  localparam logic [1:0] MISC_MOVW = 2'b01;

  // status register bit positions
  localparam int FLAG_C = 0;
  localparam int FLAG_Z = 1;
  localparam int FLAG_N = 2;
  localparam int FLAG_V = 3;
  localparam int FLAG_S = 4;
  localparam int FLAG_H = 5;

  // input tdata field offsets
  localparam int IN_WORD_LSB = 0;
  localparam int IN_HIDX_LSB = 16;
  localparam int IN_HVAL_LSB = 21;

  // output tdata / tuser field offsets
  localparam int OUT_DIDX_LSB  = 0;
  localparam int OUT_DVAL_LSB  = 5;
  localparam int OUT_SREG_LSB  = 21;
  localparam int OUT_RDATA_LSB = 29;
  localparam int OUT_PAD_W     = OUT_TDATA_W - 37;
  localparam int OUT_UNIMPL_BIT = 0;
  localparam int OUT_WR_LSB     = 1;

endpackage : avr_alu_pkg

`default_nettype wire

@@ rtl/avr_alu_add_sub_movw_top.sv @@
// avr alu slice: decode, register file pair memory, flag logic, output register
// depends on avr_alu_pkg
// pipeline: memory read register, then execute into the output register
// throughput: one transaction per cycle while the output is not stalled, set by the single
//   pass through the pair memory read and write-back with one-entry write forwarding
// reset: status register cleared, per-register valid bits cleared so the
//   register file reads as zero until written; no clearing pass
`default_nettype none

module avr_alu_add_sub_movw_top #(
  parameter int NUM_REGS = avr_alu_pkg::NUM_REGS_DEF
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               in_tvalid,
  output logic                                    in_tready,
  // instr_word[15:0], host_reg_index[20:16], host_value[28:21], zero[31:29]
  input  wire logic [avr_alu_pkg::IN_TDATA_W-1:0] in_tdata,
  // op[1:0]
  input  wire logic [avr_alu_pkg::IN_TUSER_W-1:0] in_tuser,
  output logic                                    out_tvalid,
  input  wire logic                               out_tready,
  // dest_index[4:0], dest_value[20:5], status_after[28:21], read_data[36:29],
  // zero[39:37]
  output logic [avr_alu_pkg::OUT_TDATA_W-1:0]     out_tdata,
  // unimplemented[0], reg_written[2:1]
  output logic [avr_alu_pkg::OUT_TUSER_W-1:0]     out_tuser
);
  import avr_alu_pkg::*;

  localparam int ROWS = NUM_REGS / 2;
  localparam int RAW  = $clog2(ROWS);

  // input unpack
  logic [1:0]  in_op;
  logic [15:0] in_w;
  logic [4:0]  in_hidx;
  logic [7:0]  in_hval;
  logic [4:0]  in_r5;
  logic        in_acc;

  assign in_op   = in_tuser[1:0];
  assign in_w    = in_tdata[IN_WORD_LSB +: 16];
  assign in_hidx = in_tdata[IN_HIDX_LSB +: 5];
  assign in_hval = in_tdata[IN_HVAL_LSB +: 8];
  assign in_r5   = {in_w[9], in_w[3:0]};
  assign in_acc  = in_tvalid && in_tready;

  // read row selection: port a carries rd or the host register, port b rr or movw source
  logic [RAW-1:0] rd_a_row;
  logic [RAW-1:0] rd_b_row;

  always_comb begin
    if (in_op == OP_EXEC) begin
      rd_a_row = in_w[4+RAW:5];
    end else begin
      rd_a_row = in_hidx[RAW:1];
    end
    if (in_w[15:10] == 6'd0) begin
      rd_b_row = in_w[RAW-1:0];
    end else begin
      rd_b_row = in_r5[RAW:1];
    end
  end

  // pair memory: odd register in the high byte, even register in the low byte
  logic [15:0]    mem [ROWS];
  logic [15:0]    rd_a_q;
  logic [15:0]    rd_b_q;
  logic           wr_en;
  logic           wr_go;
  logic [RAW-1:0] wr_row;
  logic [1:0]     wr_be;
  logic [15:0]    wr_data;

  always_ff @(posedge clk) begin
    if (wr_go) begin
      if (wr_be[0]) begin
        mem[wr_row][7:0] <= wr_data[7:0];
      end
      if (wr_be[1]) begin
        mem[wr_row][15:8] <= wr_data[15:8];
      end
    end
    if (in_acc) begin
      rd_a_q <= mem[rd_a_row];
      rd_b_q <= mem[rd_b_row];
    end
  end

  // pipeline control
  logic s1_v_r;
  logic out_v_r;
  logic s1_adv;

  assign s1_adv    = s1_v_r && (!out_v_r || out_tready);
  assign in_tready = !s1_v_r || s1_adv;
  assign wr_go     = s1_adv && wr_en;

  // execute stage payload
  logic [1:0]     s1_op_r;
  logic [15:0]    s1_w_r;
  logic [4:0]     s1_hidx_r;
  logic [7:0]     s1_hval_r;
  logic [RAW-1:0] s1_a_row_r;
  logic [RAW-1:0] s1_b_row_r;

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_op_r    <= in_op;
      s1_w_r     <= in_w;
      s1_hidx_r  <= in_hidx;
      s1_hval_r  <= in_hval;
      s1_a_row_r <= rd_a_row;
      s1_b_row_r <= rd_b_row;
    end
  end

  // state beside the memory: status, valid bits, last write for forwarding
  logic [7:0]            sreg_r;
  logic [7:0]            sreg_nxt;
  logic [ROWS-1:0][1:0]  vld_r;
  logic [RAW-1:0]        fwd_row_r;
  logic [1:0]            fwd_be_r;
  logic [15:0]           fwd_data_r;

  // read data with forwarding of the write that landed on the read edge
  logic [15:0] row_a;
  logic [15:0] row_b;

  always_comb begin
    for (int k = 0; k < 2; k++) begin
      if (fwd_be_r[k] && (fwd_row_r == s1_a_row_r)) begin
        row_a[8*k +: 8] = fwd_data_r[8*k +: 8];
      end else if (!vld_r[s1_a_row_r][k]) begin
        row_a[8*k +: 8] = 8'd0;
      end else begin
        row_a[8*k +: 8] = rd_a_q[8*k +: 8];
      end
      if (fwd_be_r[k] && (fwd_row_r == s1_b_row_r)) begin
        row_b[8*k +: 8] = fwd_data_r[8*k +: 8];
      end else if (!vld_r[s1_b_row_r][k]) begin
        row_b[8*k +: 8] = 8'd0;
      end else begin
        row_b[8*k +: 8] = rd_b_q[8*k +: 8];
      end
    end
  end

  // arithmetic group decode
  logic [3:0] kind;
  logic [4:0] d5;
  logic [4:0] r5;
  logic       alu_ok;
  logic       is_sub;
  logic       use_c;
  logic       store;
  logic       keepz;

  assign kind = s1_w_r[13:10];
  assign d5   = s1_w_r[8:4];
  assign r5   = {s1_w_r[9], s1_w_r[3:0]};

  always_comb begin
    alu_ok = 1'b1;
    is_sub = 1'b1;
    use_c  = 1'b0;
    store  = 1'b1;
    keepz  = 1'b0;
    case (kind)
      KIND_ADD: begin
        is_sub = 1'b0;
      end
      KIND_ADC: begin
        is_sub = 1'b0;
        use_c  = 1'b1;
      end
      KIND_SUB: begin
      end
      KIND_SBC: begin
        use_c = 1'b1;
        keepz = 1'b1;
      end
      KIND_CP: begin
        store = 1'b0;
      end
      KIND_CPC: begin
        use_c = 1'b1;
        keepz = 1'b1;
        store = 1'b0;
      end
      default: begin
        alu_ok = 1'b0;
      end
    endcase
  end

  // add / subtract and flags
  logic [7:0] opa;
  logic [7:0] opb;
  logic       cc;
  logic [8:0] sum9;
  logic [7:0] res;
  logic [7:0] vv;
  logic [7:0] hh;
  logic       zf;
  logic       nf;
  logic [7:0] alu_sreg;

  always_comb begin
    opa = d5[0] ? row_a[15:8] : row_a[7:0];
    opb = r5[0] ? row_b[15:8] : row_b[7:0];
    cc  = use_c && sreg_r[FLAG_C];
    if (is_sub) begin
      sum9 = {1'b0, opa} - {1'b0, opb} - {8'd0, cc};
      vv   = (opa & ~opb & ~sum9[7:0]) | (~opa & opb & sum9[7:0]);
      hh   = (~opa & opb) | (opb & sum9[7:0]) | (sum9[7:0] & ~opa);
    end else begin
      sum9 = {1'b0, opa} + {1'b0, opb} + {8'd0, cc};
      vv   = (opa & opb & ~sum9[7:0]) | (~opa & ~opb & sum9[7:0]);
      hh   = (opa & opb) | (opb & ~sum9[7:0]) | (~sum9[7:0] & opa);
    end
    res = sum9[7:0];
    nf  = res[7];
    if (keepz) begin
      zf = (res == 8'd0) ? sreg_r[FLAG_Z] : 1'b0;
    end else begin
      zf = (res == 8'd0);
    end
    alu_sreg = {sreg_r[7:6], hh[3], nf ^ vv[7], vv[7], nf, zf, sum9[8]};
  end

  // result and write-back selection
  logic        unimpl;
  logic [1:0]  written;
  logic [4:0]  didx;
  logic [15:0] dval;
  logic [7:0]  rdata;

  always_comb begin
    unimpl   = 1'b0;
    written  = WR_NONE;
    didx     = 5'd0;
    dval     = 16'd0;
    rdata    = 8'd0;
    sreg_nxt = sreg_r;
    wr_en    = 1'b0;
    wr_row   = '0;
    wr_be    = 2'b00;
    wr_data  = 16'd0;
    case (s1_op_r)
      OP_WR_REG: begin
        wr_en   = 1'b1;
        wr_row  = s1_hidx_r[RAW:1];
        wr_be   = s1_hidx_r[0] ? 2'b10 : 2'b01;
        wr_data = {s1_hval_r, s1_hval_r};
        written = WR_BYTE;
        didx    = s1_hidx_r;
        dval    = {8'd0, s1_hval_r};
      end
      OP_RD_REG: begin
        rdata = s1_hidx_r[0] ? row_a[15:8] : row_a[7:0];
      end
      OP_WR_SREG: begin
        sreg_nxt = s1_hval_r;
      end
      default: begin
        if (s1_w_r[15:10] == 6'd0) begin
          case (s1_w_r[9:8])
            MISC_NOP: begin
            end
            MISC_MOVW: begin
              wr_en   = 1'b1;
              wr_row  = s1_w_r[3+RAW:4];
              wr_be   = 2'b11;
              wr_data = row_b;
              written = WR_PAIR;
              didx    = {s1_w_r[7:4], 1'b0};
              dval    = row_b;
            end
            default: begin
              unimpl = 1'b1;
            end
          endcase
        end else if (s1_w_r[15:14] == 2'b00 && alu_ok) begin
          sreg_nxt = alu_sreg;
          if (store) begin
            wr_en   = 1'b1;
            wr_row  = d5[RAW:1];
            wr_be   = d5[0] ? 2'b10 : 2'b01;
            wr_data = {res, res};
            written = WR_BYTE;
            didx    = d5;
            dval    = {8'd0, res};
          end
        end else begin
          unimpl = 1'b1;
        end
      end
    endcase
  end

  // control and state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r   <= 1'b0;
      out_v_r  <= 1'b0;
      sreg_r   <= 8'd0;
      vld_r    <= '0;
      fwd_be_r <= 2'b00;
    end else begin
      if (in_acc) begin
        s1_v_r <= 1'b1;
      end else if (s1_adv) begin
        s1_v_r <= 1'b0;
      end
      if (s1_adv) begin
        out_v_r <= 1'b1;
        sreg_r  <= sreg_nxt;
      end else if (out_tready) begin
        out_v_r <= 1'b0;
      end
      if (wr_go) begin
        vld_r[wr_row] <= vld_r[wr_row] | wr_be;
        fwd_be_r      <= wr_be;
      end
    end
  end

  // forwarding payload
  always_ff @(posedge clk) begin
    if (wr_go) begin
      fwd_row_r  <= wr_row;
      fwd_data_r <= wr_data;
    end
  end

  // output register
  logic [OUT_TDATA_W-1:0] out_data_r;
  logic [OUT_TUSER_W-1:0] out_user_r;

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_data_r <= {{OUT_PAD_W{1'b0}}, rdata, sreg_nxt, dval, didx};
      out_user_r <= {written, unimpl};
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

endmodule : avr_alu_add_sub_movw_top

`default_nettype wire

@@ rtl/avr_alu_chk.sv @@
// port-level checker for the avr alu slice, bound to the top level
// depends on avr_alu_pkg and avr_alu_add_sub_movw_top
`default_nettype none

module avr_alu_chk (
  input wire logic                                clk,
  input wire logic                                rst_n,
  input wire logic                                out_tvalid,
  input wire logic                                out_tready,
  input wire logic [avr_alu_pkg::OUT_TDATA_W-1:0] out_tdata,
  input wire logic [avr_alu_pkg::OUT_TUSER_W-1:0] out_tuser
);
  import avr_alu_pkg::*;

  // a stalled result transaction holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result changed while stalled");

  // an unimplemented opcode reports no register write
  a_unimpl_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[OUT_UNIMPL_BIT] |->
      out_tuser[OUT_WR_LSB +: 2] == WR_NONE && out_tdata[20:0] == 21'd0)
    else $error("unimplemented opcode reported a write");

  // a pair write always lands on an even register and is never flagged unimplemented
  a_pair_even: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[OUT_WR_LSB +: 2] == WR_PAIR |->
      !out_tdata[OUT_DIDX_LSB] && !out_tuser[OUT_UNIMPL_BIT])
    else $error("pair write to odd register");

  // read data only on a transaction that wrote nothing
  a_read_alone: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[OUT_RDATA_LSB +: 8] != 8'd0 |->
      out_tuser[OUT_WR_LSB +: 2] == WR_NONE && !out_tuser[OUT_UNIMPL_BIT])
    else $error("read data alongside a write");

  // no spurious result appears just after reset is released
  a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(rst_n) |-> !out_tvalid ##1 !out_tvalid)
    else $error("result appeared after reset");

endmodule : avr_alu_chk

bind avr_alu_add_sub_movw_top avr_alu_chk u_avr_alu_chk (.*);

`default_nettype wire

@@ tb/tb_avr_alu_add_sub_movw_top.sv @@
// self-checking testbench for avr_alu_add_sub_movw_top: directed and random instruction streams
// with a cycle-free predictor of the register file and status flags; depends on avr_alu_pkg
`timescale 1ns / 1ps

module tb_avr_alu_add_sub_movw_top;
  import avr_alu_pkg::*;

  // one result transaction, fields as they appear on the output stream
  typedef struct packed {
    logic        unimpl;
    logic [1:0]  wr_kind;
    logic [4:0]  dest_idx;
    logic [15:0] dest_val;
    logic [7:0]  sreg;
    logic [7:0]  rd_data;
  } alu_result_t;

  localparam int STALL_CYCLES = 80;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_tvalid = 1'b0;
  wire logic              in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata = '0;
  logic [IN_TUSER_W-1:0]  in_tuser = '0;
  wire logic              out_tvalid;
  logic                   out_tready = 1'b0;
  wire [OUT_TDATA_W-1:0]  out_tdata;
  wire [OUT_TUSER_W-1:0]  out_tuser;

  // shadow copy of the architectural state
  logic [7:0]  shadow_regs [NUM_REGS_DEF];
  logic [7:0]  shadow_sreg;

  alu_result_t pending_results [$];
  int          err_cnt = 0;
  logic        idle_en = 1'b1;
  int          stall_req_cnt = 0;
  int          stall_ack_cnt = 0;
  int          stall_left = 0;

  avr_alu_add_sub_movw_top DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  always #2 clk = ~clk;

  // flags of an 8-bit add or subtract, following the avr rules
  function automatic logic [7:0] arith_status(input logic [7:0] old, input logic [7:0] a,
                                              input logic [7:0] b, input logic [7:0] r,
                                              input logic carry, input logic is_sub,
                                              input logic keep_z);
    logic [7:0] s;
    logic [7:0] v;
    logic [7:0] h;
    s = {old[7:6], 6'b0};
    s[FLAG_C] = carry;
    s[FLAG_Z] = keep_z ? ((r == 8'h00) && old[FLAG_Z]) : (r == 8'h00);
    if (is_sub) begin
      v = (a & ~b & ~r) | (~a & b & r);
      h = (~a & b) | (b & r) | (r & ~a);
    end else begin
      v = (a & b & ~r) | (~a & ~b & r);
      h = (a & b) | (b & ~r) | (~r & a);
    end
    s[FLAG_N] = r[7];
    s[FLAG_V] = v[7];
    s[FLAG_S] = r[7] ^ v[7];
    s[FLAG_H] = h[3];
    return s;
  endfunction

  // advance the shadow state by one transaction and return the result it produces
  function automatic alu_result_t predict_alu_step(input logic [1:0] op,
                                                   input logic [15:0] word,
                                                   input logic [4:0] idx,
                                                   input logic [7:0] val);
    alu_result_t res;
    logic [4:0]  rd;
    logic [4:0]  rr;
    logic [7:0]  a;
    logic [7:0]  b;
    logic        cin;
    logic        is_sub;
    logic        use_c;
    logic        store;
    logic        keep_z;
    logic [8:0]  full;
    res = '0;
    case (op)
      OP_WR_REG: begin
        shadow_regs[idx] = val;
        res.wr_kind = WR_BYTE;
        res.dest_idx = idx;
        res.dest_val = {8'h00, val};
      end
      OP_RD_REG: begin
        res.rd_data = shadow_regs[idx];
      end
      OP_WR_SREG: begin
        shadow_sreg = val;
      end
      default: begin
        if (word[15:10] == 6'b000000) begin
          // misc group: nop range and register pair move
          if (word[9:8] == MISC_MOVW) begin
            rd = {word[7:4], 1'b0};
            rr = {word[3:0], 1'b0};
            a = shadow_regs[rr + 5'd1];
            b = shadow_regs[rr];
            shadow_regs[rd + 5'd1] = a;
            shadow_regs[rd] = b;
            res.wr_kind = WR_PAIR;
            res.dest_idx = rd;
            res.dest_val = {a, b};
          end else if (word[9:8] != MISC_NOP) begin
            res.unimpl = 1'b1;
          end
        end else if (word[15:14] == 2'b00) begin
          // two-register arithmetic group
          rd = word[8:4];
          rr = {word[9], word[3:0]};
          a = shadow_regs[rd];
          b = shadow_regs[rr];
          cin = shadow_sreg[FLAG_C];
          is_sub = 1'b1;
          use_c = 1'b0;
          store = 1'b1;
          keep_z = 1'b0;
          case (word[13:10])
            KIND_ADD: is_sub = 1'b0;
            KIND_ADC: begin
              is_sub = 1'b0;
              use_c = 1'b1;
            end
            KIND_SUB: ;
            KIND_SBC: begin
              use_c = 1'b1;
              keep_z = 1'b1;
            end
            KIND_CP:  store = 1'b0;
            KIND_CPC: begin
              use_c = 1'b1;
              keep_z = 1'b1;
              store = 1'b0;
            end
            default:  res.unimpl = 1'b1;
          endcase
          if (!res.unimpl) begin
            if (is_sub) full = {1'b0, a} - {1'b0, b} - {8'h00, use_c & cin};
            else        full = {1'b0, a} + {1'b0, b} + {8'h00, use_c & cin};
            shadow_sreg = arith_status(shadow_sreg, a, b, full[7:0], full[8], is_sub, keep_z);
            if (store) begin
              shadow_regs[rd] = full[7:0];
              res.wr_kind = WR_BYTE;
              res.dest_idx = rd;
              res.dest_val = {8'h00, full[7:0]};
            end
          end
        end else begin
          res.unimpl = 1'b1;
        end
      end
    endcase
    res.sreg = shadow_sreg;
    return res;
  endfunction

  function automatic logic [15:0] enc_arith(input logic [3:0] kind, input logic [4:0] rd,
                                            input logic [4:0] rr);
    return {2'b00, kind, rr[4], rd, rr[3:0]};
  endfunction

  function automatic logic [15:0] enc_movw(input logic [3:0] rd_pair, input logic [3:0] rr_pair);
    return {6'b000000, MISC_MOVW, rd_pair, rr_pair};
  endfunction

  // offer one transaction, wait for its acceptance and record what it should produce
  task automatic send_item(input logic [1:0] op, input logic [15:0] word,
                           input logic [4:0] idx, input logic [7:0] val);
    if (idle_en && $urandom_range(99) < 16) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(2, 1)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= {3'b000, val, idx, word};
    do @(posedge clk); while (!in_tready);
    pending_results.push_back(predict_alu_step(op, word, idx, val));
  endtask

  function automatic logic [15:0] rand_instr_word();
    logic [3:0] kinds [6];
    int         pick;
    kinds = '{KIND_ADD, KIND_ADC, KIND_SUB, KIND_SBC, KIND_CP, KIND_CPC};
    pick = $urandom_range(99);
    if (pick < 70)
      return enc_arith(kinds[$urandom_range(5)], 5'($urandom), 5'($urandom));
    else if (pick < 80)
      return enc_movw(4'($urandom), 4'($urandom));
    else if (pick < 83)
      return {8'h00, 8'($urandom)};
    else
      return 16'($urandom);
  endfunction

  // random transaction, mostly instructions with some host traffic mixed in
  task automatic send_random_item();
    int pick;
    pick = $urandom_range(99);
    if (pick < 70)
      send_item(OP_EXEC, rand_instr_word(), 5'($urandom), 8'($urandom));
    else if (pick < 82)
      send_item(OP_WR_REG, 16'($urandom), 5'($urandom), 8'($urandom));
    else if (pick < 90)
      send_item(OP_RD_REG, 16'($urandom), 5'($urandom), 8'($urandom));
    else
      send_item(OP_WR_SREG, 16'($urandom), 5'($urandom), 8'($urandom));
  endtask

  task automatic wait_drain();
    while (pending_results.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  // host preload, readback and status writes at the extremes
  task automatic test_host_access();
    send_item(OP_WR_REG, 16'h0000, 5'd0, 8'hFF);
    send_item(OP_WR_REG, 16'hFFFF, 5'd31, 8'h80);
    send_item(OP_RD_REG, 16'h0000, 5'd31, 8'h00);
    send_item(OP_RD_REG, 16'hFFFF, 5'd0, 8'hFF);
    send_item(OP_WR_SREG, 16'h0000, 5'd0, 8'hFF);
    send_item(OP_WR_SREG, 16'h0000, 5'd31, 8'h00);
  endtask

  // add and subtract with wrap, overflow and half carry, rr with bit 4 set
  task automatic test_add_sub_flags();
    send_item(OP_WR_REG, 16'h0000, 5'd17, 8'h01);
    send_item(OP_EXEC, enc_arith(KIND_ADD, 5'd0, 5'd17), 5'd0, 8'h00);
    send_item(OP_EXEC, enc_arith(KIND_ADC, 5'd0, 5'd17), 5'd0, 8'h00);
    send_item(OP_EXEC, enc_arith(KIND_SUB, 5'd31, 5'd17), 5'd0, 8'h00);
    send_item(OP_EXEC, enc_arith(KIND_CP, 5'd17, 5'd31), 5'd0, 8'h00);
  endtask

  // sbc and cpc keep a set zero flag on a zero result and clear it otherwise
  task automatic test_zero_keep();
    send_item(OP_WR_REG, 16'h0000, 5'd2, 8'h05);
    send_item(OP_WR_REG, 16'h0000, 5'd3, 8'h04);
    send_item(OP_WR_SREG, 16'h0000, 5'd0, 8'((1 << FLAG_Z) | (1 << FLAG_C)));
    send_item(OP_EXEC, enc_arith(KIND_SBC, 5'd2, 5'd3), 5'd0, 8'h00);
    send_item(OP_EXEC, enc_arith(KIND_CPC, 5'd3, 5'd2), 5'd0, 8'h00);
    send_item(OP_WR_SREG, 16'h0000, 5'd0, 8'(1 << FLAG_C));
    send_item(OP_EXEC, enc_arith(KIND_CPC, 5'd3, 5'd2), 5'd0, 8'h00);
  endtask

  // pair moves at both ends of the file and both ends of the nop range
  task automatic test_movw_nop();
    send_item(OP_EXEC, enc_movw(4'd15, 4'd0), 5'd0, 8'h00);
    send_item(OP_EXEC, enc_movw(4'd0, 4'd15), 5'd0, 8'h00);
    send_item(OP_EXEC, 16'h0000, 5'd0, 8'h00);
    send_item(OP_EXEC, 16'h00FF, 5'd0, 8'h00);
  endtask

  // opcodes outside the subset leave all state alone
  task automatic test_unimplemented();
    send_item(OP_EXEC, 16'h0200, 5'd0, 8'h00);
    send_item(OP_EXEC, 16'h0300, 5'd0, 8'h00);
    send_item(OP_EXEC, 16'h1000, 5'd0, 8'h00);
    send_item(OP_EXEC, 16'h2C00, 5'd0, 8'h00);
    send_item(OP_EXEC, 16'hFFFF, 5'd0, 8'h00);
  endtask

  task automatic test_random_mix(input int count);
    repeat (count) send_random_item();
  endtask

  // back-to-back traffic on both sides
  task automatic test_no_idle_burst(input int count);
    idle_en <= 1'b0;
    repeat (count) send_random_item();
    idle_en <= 1'b1;
  endtask

  // receiver holds off while the sender keeps offering, so the block must stall its input
  task automatic test_backpressure(input int count);
    stall_req_cnt <= stall_req_cnt + 1;
    repeat (count) send_random_item();
  endtask

  // result side ready, with random idling and requested long stalls
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (stall_req_cnt != stall_ack_cnt) begin
      stall_ack_cnt <= stall_req_cnt;
      stall_left <= STALL_CYCLES;
      out_tready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= idle_en ? ($urandom_range(99) >= 19) : 1'b1;
    end
  end

  function automatic void check_field(input string name, input int want, input int got);
    if (want != got) begin
      $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
      err_cnt++;
    end
  endfunction

  // compare each result transaction with the oldest prediction
  always @(posedge clk) begin
    alu_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_results.size() == 0) begin
        $error("result transaction with no prediction pending: tuser 0x%0h tdata 0x%0h",
               out_tuser, out_tdata);
        err_cnt++;
      end else begin
        want = pending_results.pop_front();
        check_field("unimplemented", want.unimpl, out_tuser[OUT_UNIMPL_BIT]);
        check_field("reg_written", want.wr_kind, out_tuser[OUT_WR_LSB +: 2]);
        check_field("dest_index", want.dest_idx, out_tdata[OUT_DIDX_LSB +: 5]);
        check_field("dest_value", want.dest_val, out_tdata[OUT_DVAL_LSB +: 16]);
        check_field("status_after", want.sreg, out_tdata[OUT_SREG_LSB +: 8]);
        check_field("read_data", want.rd_data, out_tdata[OUT_RDATA_LSB +: 8]);
      end
    end
  end

  // test sequence
  initial begin
    for (int i = 0; i < NUM_REGS_DEF; i++) shadow_regs[i] = 8'h00;
    shadow_sreg = 8'h00;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_host_access();
    test_add_sub_flags();
    test_zero_keep();
    test_movw_nop();
    test_unimplemented();
    test_random_mix(400);
    test_no_idle_burst(150);
    test_backpressure(50);
    in_tvalid <= 1'b0;
    wait_drain();

    if (pending_results.size() != 0) begin
      $error("%0d predicted results never arrived", pending_results.size());
      err_cnt++;
    end
    if (err_cnt == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // watchdog
  initial begin
    #2_000_000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule
